>>> src/lap_pkg.sv
// ============================================================================
// Laplacian stencil package
// Shared widths, register indexes and the types passed between the stencil
// front end and the arithmetic pipeline.
// ============================================================================
`default_nettype none

package lap_pkg;

    localparam int DEF_MAX_ROW    = 64;
    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_PLANES = 64;
    localparam int DEF_FRAC_BITS  = 16;

    localparam int SAMPLE_W  = 32;
    localparam int CFG_DIM_W = 7;
    localparam int CFG_IDX_W = 3;
    localparam int POS_W     = 6;
    // Stencil sum: at most twelve times a 32-bit magnitude.
    localparam int SUM_W     = 36;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THREE_DIM   = 3'd0,
        REG_ROW_LENGTH  = 3'd1,
        REG_ROWS_PLANE  = 3'd2,
        REG_PLANE_COUNT = 3'd3,
        REG_GAIN        = 3'd4,
        REG_ACCUMULATE  = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic             last;
    } pos_t;

    // Neighbors around the centre. back and fwd run along y in 2D and along
    // z in 3D; ym and yp are only used in 3D.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] centre;
        logic signed [SAMPLE_W-1:0] xm;
        logic signed [SAMPLE_W-1:0] xp;
        logic signed [SAMPLE_W-1:0] ym;
        logic signed [SAMPLE_W-1:0] yp;
        logic signed [SAMPLE_W-1:0] back;
        logic signed [SAMPLE_W-1:0] fwd;
    } taps_t;

    typedef struct packed {
        taps_t                      taps;
        logic signed [SAMPLE_W-1:0] prior;
        pos_t                       pos;
    } req_t;

endpackage

`default_nettype wire

>>> src/lap_delay_line.sv
// ============================================================================
// Programmable delay line
// Circular buffer that returns the word written a given number of requests
// ago. The read is fetched one request ahead into a register; a delay of
// zero passes the input straight through. Supported delays: 0 and 2..DEPTH.
// ============================================================================
`default_nettype none

module lap_delay_line
    import lap_pkg::*;
#(
    parameter int DEPTH   = 64,
    parameter int WIDTH   = 32,
    parameter int DELAY_W = 7
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               advance,
    input  wire logic [WIDTH-1:0]   din,
    input  wire logic [DELAY_W-1:0] delay,
    output logic      [WIDTH-1:0]   dout
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = ((AW > DELAY_W) ? AW : DELAY_W) + 2;

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_reg;
    logic [AW-1:0]    wptr_reg;
    logic [AW-1:0]    wptr_next;
    logic [SW-1:0]    base;
    logic [SW-1:0]    dly;
    logic [SW-1:0]    rd_addr_w;
    logic [AW-1:0]    rd_addr;

    // Prefetch the entry the next request will need: (wptr + 1 - delay) mod DEPTH.
    always_comb
    begin
        base = SW'(wptr_reg) + SW'(1);
        dly  = SW'(delay);
        if (base >= dly)
        begin
            rd_addr_w = base - dly;
        end
        else
        begin
            rd_addr_w = base + SW'(DEPTH) - dly;
        end
        rd_addr   = rd_addr_w[AW-1:0];
        wptr_next = (wptr_reg == AW'(DEPTH - 1)) ? '0 : wptr_reg + AW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mem[wptr_reg] <= din;
            rd_reg        <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
        end
        else if (advance)
        begin
            wptr_reg <= wptr_next;
        end
    end

    assign dout = (delay == '0) ? din : rd_reg;

endmodule

`default_nettype wire

>>> src/lap_arith.sv
// ============================================================================
// Stencil arithmetic pipeline
// Six stages: capture, stencil sum, split multiply, product merge, rounding
// with saturation, and accumulation into the output register.
// ============================================================================
`default_nettype none

module lap_arith
    import lap_pkg::*;
#(
    parameter int FRAC_BITS = DEF_FRAC_BITS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       load,
    input  wire req_t                       req,
    input  wire logic                       three_d,
    input  wire logic                       accumulate,
    input  wire logic signed [SAMPLE_W-1:0] gain,
    output logic                            ready,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [SAMPLE_W-1:0]      value,
    output pos_t                            out_pos
);

    localparam int PLO_W  = 2 * SAMPLE_W + 1;
    localparam int PHI_W  = SAMPLE_W + SUM_W - SAMPLE_W;
    localparam int PROD_W = SAMPLE_W + SUM_W;
    localparam int RND_W  = PROD_W + 1;
    localparam longint ONE  = 64'sd1 <<< FRAC_BITS;
    localparam longint HALF = ONE >>> 1;
    localparam logic signed [RND_W-1:0] OFS_POS = RND_W'(HALF);
    localparam logic signed [RND_W-1:0] OFS_NEG = RND_W'(ONE - 64'sd1 - HALF);
    localparam logic signed [RND_W-1:0] RND_MAX = RND_W'(64'sd2147483647);
    localparam logic signed [RND_W-1:0] RND_MIN = RND_W'(-64'sd2147483648);
    localparam logic signed [SAMPLE_W:0] ACC_MAX = (SAMPLE_W+1)'(64'sd2147483647);
    localparam logic signed [SAMPLE_W:0] ACC_MIN = (SAMPLE_W+1)'(-64'sd2147483648);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg;
    logic en1, en2, en3, en4, en5, en6;

    req_t                      req1_reg;
    logic signed [SUM_W-1:0]   sum2_reg;
    logic signed [SAMPLE_W-1:0] prior2_reg, prior3_reg, prior4_reg, prior5_reg;
    pos_t                      pos2_reg, pos3_reg, pos4_reg, pos5_reg, pos6_reg;
    logic signed [PLO_W-1:0]   plo3_reg;
    logic signed [PHI_W-1:0]   phi3_reg;
    logic signed [PROD_W-1:0]  prod4_reg;
    logic signed [SAMPLE_W-1:0] rnd5_reg;
    logic signed [SAMPLE_W-1:0] value6_reg;

    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W-1:0]   c_ext;
    logic signed [PLO_W-1:0]   plo_next;
    logic signed [PHI_W-1:0]   phi_next;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [RND_W-1:0]   rnd_sum;
    logic signed [RND_W-1:0]   rnd_shift;
    logic signed [SAMPLE_W-1:0] rnd_next;
    logic signed [SAMPLE_W:0]  acc_sum;
    logic signed [SAMPLE_W-1:0] value_next;

    // A stage takes new data when it is empty or its content moves on.
    assign en6   = !v6_reg || !out_stall;
    assign en5   = !v5_reg || en6;
    assign en4   = !v4_reg || en5;
    assign en3   = !v3_reg || en4;
    assign en2   = !v2_reg || en3;
    assign en1   = !v1_reg || en2;
    assign ready = en1;

    always_comb
    begin
        c_ext    = SUM_W'($signed(req1_reg.taps.centre));
        sum_next = SUM_W'($signed(req1_reg.taps.xm)) + SUM_W'($signed(req1_reg.taps.xp))
                 + SUM_W'($signed(req1_reg.taps.back)) + SUM_W'($signed(req1_reg.taps.fwd));
        if (three_d)
        begin
            sum_next = sum_next + SUM_W'($signed(req1_reg.taps.ym))
                     + SUM_W'($signed(req1_reg.taps.yp))
                     - (c_ext <<< 2) - (c_ext <<< 1);
        end
        else
        begin
            sum_next = sum_next - (c_ext <<< 2);
        end

        plo_next = PLO_W'(gain) * $signed({1'b0, sum2_reg[SAMPLE_W-1:0]});
        phi_next = PHI_W'(gain) * PHI_W'($signed(sum2_reg[SUM_W-1:SAMPLE_W]));

        prod_next = (PROD_W'(phi3_reg) <<< SAMPLE_W) + PROD_W'(plo3_reg);

        // Round to nearest with ties away from zero, then saturate.
        rnd_sum   = RND_W'(prod4_reg) + ((prod4_reg < 0) ? OFS_NEG : OFS_POS);
        rnd_shift = rnd_sum >>> FRAC_BITS;
        if (rnd_shift > RND_MAX)
        begin
            rnd_next = RND_MAX[SAMPLE_W-1:0];
        end
        else if (rnd_shift < RND_MIN)
        begin
            rnd_next = RND_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            rnd_next = rnd_shift[SAMPLE_W-1:0];
        end

        acc_sum = (SAMPLE_W+1)'(rnd5_reg) + (SAMPLE_W+1)'(prior5_reg);
        if (!accumulate)
        begin
            value_next = rnd5_reg;
        end
        else if (acc_sum > ACC_MAX)
        begin
            value_next = ACC_MAX[SAMPLE_W-1:0];
        end
        else if (acc_sum < ACC_MIN)
        begin
            value_next = ACC_MIN[SAMPLE_W-1:0];
        end
        else
        begin
            value_next = acc_sum[SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= load;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && load)
        begin
            req1_reg <= req;
        end
        if (en2)
        begin
            sum2_reg   <= sum_next;
            prior2_reg <= req1_reg.prior;
            pos2_reg   <= req1_reg.pos;
        end
        if (en3)
        begin
            plo3_reg   <= plo_next;
            phi3_reg   <= phi_next;
            prior3_reg <= prior2_reg;
            pos3_reg   <= pos2_reg;
        end
        if (en4)
        begin
            prod4_reg  <= prod_next;
            prior4_reg <= prior3_reg;
            pos4_reg   <= pos3_reg;
        end
        if (en5)
        begin
            rnd5_reg   <= rnd_next;
            prior5_reg <= prior4_reg;
            pos5_reg   <= pos4_reg;
        end
        if (en6)
        begin
            value6_reg <= value_next;
            pos6_reg   <= pos5_reg;
        end
    end

    assign out_valid = v6_reg;
    assign value     = value6_reg;
    assign out_pos   = pos6_reg;

endmodule

`default_nettype wire

>>> src/laplace_stencil_2d_3d.sv
// ============================================================================
// Streaming discrete Laplacian, five-point (2D) and seven-point (3D)
// Raster-order samples pass through row and plane delay lines; each interior
// point yields gain * (neighbor sum - 4 or 6 * centre), optionally added to
// the delayed prior output, in saturated fixed point.
// ============================================================================
//
//  Channel  Handshake               Payload
//  -------  ----------------------  ---------------------------------------
//  cfg      cfg_write               cfg_index, cfg_data
//  in       in_valid / in_stall     sample, prior_output
//  out      out_valid / out_stall   value, pos_x, pos_y, pos_z, last
//
// One request is taken per clock while in_stall is low; the delay lines read
// one word per line per request, so the rate is one sample per cycle. Each
// result is registered through the arithmetic stages. Reset clears the raster
// counters and the pipeline valid bits; delay line contents need no clearing.
// Requests keep flowing into empty pipeline stages while a result is held by
// out_stall; in_stall rises only when every stage is occupied.
`default_nettype none

module laplace_stencil_2d_3d
    import lap_pkg::*;
#(
    parameter int MAX_ROW    = DEF_MAX_ROW,
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_PLANES = DEF_MAX_PLANES,
    parameter int FRAC_BITS  = DEF_FRAC_BITS
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_write,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [SAMPLE_W-1:0]        cfg_data,
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic signed [SAMPLE_W-1:0] sample,
    input  wire logic signed [SAMPLE_W-1:0] prior_output,
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic signed [SAMPLE_W-1:0]      value,
    output logic [POS_W-1:0]                pos_x,
    output logic [POS_W-1:0]                pos_y,
    output logic [POS_W-1:0]                pos_z,
    output logic                            last
);

    localparam int XW0 = $clog2(MAX_ROW + 1);
    localparam int YW0 = $clog2(MAX_ROWS + 1);
    localparam int ZW0 = $clog2(MAX_PLANES + 1);
    localparam int XW  = (XW0 > CFG_DIM_W) ? XW0 : CFG_DIM_W;
    localparam int YW  = (YW0 > CFG_DIM_W) ? YW0 : CFG_DIM_W;
    localparam int ZW  = (ZW0 > CFG_DIM_W) ? ZW0 : CFG_DIM_W;
    localparam int PW  = XW + YW;
    localparam int ROW_DEPTH   = MAX_ROW;
    localparam int PLANE_DEPTH = MAX_ROW * MAX_ROWS;

    // Configuration registers
    logic                       three_d_reg;
    logic [CFG_DIM_W-1:0]       row_length_reg;
    logic [CFG_DIM_W-1:0]       rows_plane_reg;
    logic [CFG_DIM_W-1:0]       plane_count_reg;
    logic signed [SAMPLE_W-1:0] gain_reg;
    logic                       accumulate_reg;
    logic                       restart;

    // Raster position
    logic [XW-1:0] x_reg, x_next;
    logic [YW-1:0] y_reg, y_next;
    logic [ZW-1:0] z_reg, z_next;

    logic [XW-1:0] nx, nx_raw;
    logic [YW-1:0] ny, ny_raw;
    logic [ZW-1:0] nz, nz_raw;
    logic [PW-1:0] plane_size;
    logic [PW-1:0] dly_plane;
    logic [PW-1:0] dly_prior;
    logic [XW-1:0] dly_row;

    logic accept;
    logic emit;
    logic inner_xy;
    logic arith_ready;

    logic [SAMPLE_W-1:0]        tap_yp, tap_xp, tap_ym, tap_back, tap_prior;
    logic signed [SAMPLE_W-1:0] centre_reg;
    logic signed [SAMPLE_W-1:0] west_reg;
    req_t                       req;
    pos_t                       res_pos;
    logic [YW-1:0]              y_less;
    logic [ZW-1:0]              z_less;

    assign accept   = in_valid && !in_stall;
    assign in_stall = !arith_ready;

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            three_d_reg     <= 1'b0;
            row_length_reg  <= CFG_DIM_W'(64);
            rows_plane_reg  <= CFG_DIM_W'(64);
            plane_count_reg <= CFG_DIM_W'(64);
            gain_reg        <= SAMPLE_W'(65536);
            accumulate_reg  <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_THREE_DIM:   three_d_reg     <= cfg_data[0];
                REG_ROW_LENGTH:  row_length_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_ROWS_PLANE:  rows_plane_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_PLANE_COUNT: plane_count_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_GAIN:        gain_reg        <= cfg_data;
                REG_ACCUMULATE:  accumulate_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // A geometry write sends the raster back to the origin.
    always_comb
    begin
        case (cfg_index)
            REG_THREE_DIM,
            REG_ROW_LENGTH,
            REG_ROWS_PLANE,
            REG_PLANE_COUNT: restart = cfg_write;
            default:         restart = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Geometry and delay lengths
    // ------------------------------------------------------------------
    always_comb
    begin
        nx_raw = XW'(row_length_reg);
        ny_raw = YW'(rows_plane_reg);
        nz_raw = ZW'(plane_count_reg);
        nx = (nx_raw < XW'(3)) ? XW'(3) : ((nx_raw > XW'(MAX_ROW)) ? XW'(MAX_ROW) : nx_raw);
        ny = (ny_raw < YW'(3)) ? YW'(3) :
             ((ny_raw > YW'(MAX_ROWS)) ? YW'(MAX_ROWS) : ny_raw);
        nz = (nz_raw < ZW'(3)) ? ZW'(3) :
             ((nz_raw > ZW'(MAX_PLANES)) ? ZW'(MAX_PLANES) : nz_raw);
        plane_size = PW'(nx) * PW'(ny);
        dly_row    = nx - XW'(1);
        // In 2D the plane lines collapse to wires and the row lines do the work.
        dly_plane  = three_d_reg ? (plane_size - PW'(nx)) : '0;
        dly_prior  = three_d_reg ? plane_size : PW'(nx);
    end

    // ------------------------------------------------------------------
    // Raster counters
    // ------------------------------------------------------------------
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        if (x_reg == nx - XW'(1))
        begin
            x_next = '0;
            if (y_reg == ny - YW'(1))
            begin
                y_next = '0;
                if (!three_d_reg || z_reg == nz - ZW'(1))
                begin
                    z_next = '0;
                end
                else
                begin
                    z_next = z_reg + ZW'(1);
                end
            end
            else
            begin
                y_next = y_reg + YW'(1);
            end
        end
        else
        begin
            x_next = x_reg + XW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else if (restart)
        begin
            x_reg <= '0;
            y_reg <= '0;
            z_reg <= '0;
        end
        else if (accept)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    // ------------------------------------------------------------------
    // Delay chain: yp (P-nx), xp (P-1), centre (P), xm (P+1), ym (P+nx),
    // back (2P), all counted in requests behind the incoming sample.
    // ------------------------------------------------------------------
    lap_delay_line #(
        .DEPTH   (PLANE_DEPTH),
        .WIDTH   (SAMPLE_W),
        .DELAY_W (PW)
    ) u_line_yp (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .din     (sample),
        .delay   (dly_plane),
        .dout    (tap_yp)
    );

    lap_delay_line #(
        .DEPTH   (ROW_DEPTH),
        .WIDTH   (SAMPLE_W),
        .DELAY_W (XW)
    ) u_line_xp (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .din     (tap_yp),
        .delay   (dly_row),
        .dout    (tap_xp)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            centre_reg <= tap_xp;
            west_reg   <= centre_reg;
        end
    end

    lap_delay_line #(
        .DEPTH   (ROW_DEPTH),
        .WIDTH   (SAMPLE_W),
        .DELAY_W (XW)
    ) u_line_ym (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .din     (west_reg),
        .delay   (dly_row),
        .dout    (tap_ym)
    );

    lap_delay_line #(
        .DEPTH   (PLANE_DEPTH),
        .WIDTH   (SAMPLE_W),
        .DELAY_W (PW)
    ) u_line_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .din     (tap_ym),
        .delay   (dly_plane),
        .dout    (tap_back)
    );

    lap_delay_line #(
        .DEPTH   (PLANE_DEPTH),
        .WIDTH   (SAMPLE_W),
        .DELAY_W (PW)
    ) u_line_prior (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (accept),
        .din     (prior_output),
        .delay   (dly_prior),
        .dout    (tap_prior)
    );

    // ------------------------------------------------------------------
    // Result selection and tagging
    // ------------------------------------------------------------------
    always_comb
    begin
        inner_xy = (x_reg >= XW'(1)) && (x_reg <= nx - XW'(2));
        if (three_d_reg)
        begin
            emit = (z_reg >= ZW'(2)) && inner_xy && (y_reg >= YW'(1))
                && (y_reg <= ny - YW'(2));
        end
        else
        begin
            emit = (y_reg >= YW'(2)) && inner_xy;
        end

        y_less = y_reg - YW'(1);
        z_less = z_reg - ZW'(1);
        res_pos.x    = x_reg[POS_W-1:0];
        res_pos.y    = three_d_reg ? y_reg[POS_W-1:0] : y_less[POS_W-1:0];
        res_pos.z    = three_d_reg ? z_less[POS_W-1:0] : '0;
        res_pos.last = (x_reg == nx - XW'(2))
                    && (y_reg == (three_d_reg ? ny - YW'(2) : ny - YW'(1)))
                    && (!three_d_reg || z_reg == nz - ZW'(1));

        req.taps.centre = centre_reg;
        req.taps.xm     = west_reg;
        req.taps.xp     = $signed(tap_xp);
        req.taps.ym     = $signed(tap_ym);
        req.taps.yp     = $signed(tap_yp);
        req.taps.back   = $signed(tap_back);
        req.taps.fwd    = sample;
        req.prior       = $signed(tap_prior);
        req.pos         = res_pos;
    end

    lap_arith #(
        .FRAC_BITS (FRAC_BITS)
    ) u_arith (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (accept && emit),
        .req        (req),
        .three_d    (three_d_reg),
        .accumulate (accumulate_reg),
        .gain       (gain_reg),
        .ready      (arith_ready),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .value      (value),
        .out_pos    (out_pos_w)
    );

    pos_t out_pos_w;

    assign pos_x = out_pos_w.x;
    assign pos_y = out_pos_w.y;
    assign pos_z = out_pos_w.z;
    assign last  = out_pos_w.last;

endmodule

`default_nettype wire

>>> dv/laplace_stencil_2d_3d_tb.sv
// ============================================================================
// Testbench for the streaming 2D/3D Laplacian stencil
// Streams raster-order grids through the block under many geometry, gain and
// accumulate settings. A scoreboard keeps its own copy of the delay memories
// and raster counters, predicts every interior result and checks it field by
// field. The input idles and the output stalls at random.
// ============================================================================

module laplace_stencil_2d_3d_tb;

    import lap_pkg::*;

    localparam int FRAC         = DEF_FRAC_BITS;
    localparam int SAMPLE_SLOTS = 2 * DEF_MAX_ROW * DEF_MAX_ROWS;
    localparam int PRIOR_SLOTS  = DEF_MAX_ROW * DEF_MAX_ROWS;
    localparam int ITEM_TARGET  = 1750;
    localparam int CALM_ITEMS   = 250;
    localparam int SETTLE_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int PRINT_CAP    = 100;

    // Indexes outside the register map; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483647 - 64'sd1;

    typedef struct {
        logic [SAMPLE_W-1:0] value;
        pos_t                pos;
    } stencil_out_t;

    logic                       clk          = 1'b0;
    logic                       rst_n        = 1'b0;
    logic                       cfg_write    = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index    = '0;
    logic [SAMPLE_W-1:0]        cfg_data     = '0;
    logic                       in_valid     = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample       = '0;
    logic signed [SAMPLE_W-1:0] prior_output = '0;
    logic                       out_valid;
    logic                       out_stall    = 1'b0;
    logic signed [SAMPLE_W-1:0] value;
    logic [POS_W-1:0]           pos_x;
    logic [POS_W-1:0]           pos_y;
    logic [POS_W-1:0]           pos_z;
    logic                       last;

    laplace_stencil_2d_3d DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample       (sample),
        .prior_output (prior_output),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .value        (value),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .last         (last)
    );

    // ------------------------------------------------------------------------
    // Scoreboard: mirrors the delay memories and raster position and keeps
    // the queue of interior-point results still to come.
    // ------------------------------------------------------------------------
    class stencil_model;
        logic [SAMPLE_W-1:0]  grid_mem [SAMPLE_SLOTS];
        logic [SAMPLE_W-1:0]  prior_mem [PRIOR_SLOTS];
        int                   col, row, plane;
        bit                   three_d, accumulate;
        logic [CFG_DIM_W-1:0] len_x, len_y, len_z;
        logic [SAMPLE_W-1:0]  gain;
        stencil_out_t         pending_points [$];
        int                   errors, checked, grid_ends;

        function new();
            three_d    = 1'b0;
            len_x      = 7'd64;
            len_y      = 7'd64;
            len_z      = 7'd64;
            gain       = 32'h0001_0000;
            accumulate = 1'b0;
            col        = 0;
            row        = 0;
            plane      = 0;
        endfunction

        function int span(logic [CFG_DIM_W-1:0] v, int hi);
            if (v < 3)
                return 3;
            return (v > hi) ? hi : int'(v);
        endfunction

        function int grid_points();
            return span(len_x, DEF_MAX_ROW) * span(len_y, DEF_MAX_ROWS)
                 * (three_d ? span(len_z, DEF_MAX_PLANES) : 1);
        endfunction

        // Distance in samples between the centre and its far neighbor.
        function int stride();
            return three_d ? span(len_x, DEF_MAX_ROW) * span(len_y, DEF_MAX_ROWS)
                           : span(len_x, DEF_MAX_ROW);
        endfunction

        function void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] d);
            bit restart;
            restart = 1'b1;
            case (idx)
                REG_THREE_DIM:   three_d = d[0];
                REG_ROW_LENGTH:  len_x = d[CFG_DIM_W-1:0];
                REG_ROWS_PLANE:  len_y = d[CFG_DIM_W-1:0];
                REG_PLANE_COUNT: len_z = d[CFG_DIM_W-1:0];
                REG_GAIN:
                begin
                    gain    = d;
                    restart = 1'b0;
                end
                REG_ACCUMULATE:
                begin
                    accumulate = d[0];
                    restart    = 1'b0;
                end
                default: restart = 1'b0;
            endcase
            if (restart)
            begin
                col   = 0;
                row   = 0;
                plane = 0;
            end
        endfunction

        function longint past(int lin, int back);
            longint v;
            v = $signed(grid_mem[(lin - back) % SAMPLE_SLOTS]);
            return v;
        endfunction

        function longint clip32(longint v);
            if (v > Q_MAX)
                return Q_MAX;
            if (v < Q_MIN)
                return Q_MIN;
            return v;
        endfunction

        // Exact product, rounded half away from zero, then saturated.
        function longint scale_q(longint g, longint s);
            logic [95:0] mg, ms, q;
            longint      ag, as;
            bit          neg;
            neg = (g < 0) != (s < 0);
            ag  = (g < 0) ? -g : g;
            as  = (s < 0) ? -s : s;
            mg  = ag;
            ms  = as;
            q   = (mg * ms + ((96'd1 << FRAC) >> 1)) >> FRAC;
            if (!neg)
                return (q > 96'h7FFF_FFFF) ? Q_MAX : longint'(q);
            return (q > 96'h8000_0000) ? Q_MIN : -longint'(q);
        endfunction

        function void absorb_sample(logic [SAMPLE_W-1:0] s, logic [SAMPLE_W-1:0] p);
            int           nx, ny, nz, x, y, z, lin, back;
            bit           inner_xy, emit;
            longint       centre, total, result, prior;
            stencil_out_t pt;
            nx  = span(len_x, DEF_MAX_ROW);
            ny  = span(len_y, DEF_MAX_ROWS);
            nz  = span(len_z, DEF_MAX_PLANES);
            x   = col;
            y   = row;
            z   = three_d ? plane : 0;
            lin = x + nx * (y + ny * z);
            inner_xy = (x >= 1) && (x <= nx - 2);
            if (three_d)
            begin
                emit = (z >= 2) && inner_xy && (y >= 1) && (y <= ny - 2);
                back = nx * ny;
            end
            else
            begin
                emit = (y >= 2) && inner_xy;
                back = nx;
            end

            // The arriving sample is the forward neighbor of the centre one
            // row (2D) or one plane (3D) behind it.
            if (emit)
            begin
                centre = past(lin, back);
                total  = past(lin, back + 1) + past(lin, back - 1)
                       + past(lin, 2 * back) + $signed(s);
                if (three_d)
                    total = total + past(lin, back + nx) + past(lin, back - nx) - 6 * centre;
                else
                    total = total - 4 * centre;
                result = scale_q($signed(gain), total);
                if (accumulate)
                begin
                    prior  = $signed(prior_mem[(lin - back) % PRIOR_SLOTS]);
                    result = clip32(result + prior);
                end
                pt.value    = result[SAMPLE_W-1:0];
                pt.pos.x    = x[POS_W-1:0];
                pt.pos.y    = three_d ? y[POS_W-1:0] : POS_W'(y - 1);
                pt.pos.z    = three_d ? POS_W'(z - 1) : '0;
                pt.pos.last = (x == nx - 2) && (y == (three_d ? ny - 2 : ny - 1))
                           && (!three_d || z == nz - 1);
                pending_points.push_back(pt);
            end

            grid_mem[lin % SAMPLE_SLOTS] = s;
            prior_mem[lin % PRIOR_SLOTS] = p;

            x++;
            if (x >= nx)
            begin
                x = 0;
                y++;
                if (y >= ny)
                begin
                    y = 0;
                    if (three_d)
                    begin
                        z++;
                        if (z >= nz)
                            z = 0;
                    end
                end
            end
            col   = x;
            row   = y;
            plane = three_d ? z : 0;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("MISMATCH %0d at %0t: %s", errors, $realtime, msg);
        endtask

        task compare_field(string field, logic [SAMPLE_W-1:0] got,
                           logic [SAMPLE_W-1:0] want, pos_t at);
            if (got !== want)
                report($sformatf("%s of point (%0d,%0d,%0d): got %h, want %h",
                                 field, at.x, at.y, at.z, got, want));
        endtask

        task check_point(logic [SAMPLE_W-1:0] v, pos_t got);
            stencil_out_t want;
            if (pending_points.size() == 0)
            begin
                report($sformatf("result %h at (%0d,%0d,%0d) with no request behind it",
                                 v, got.x, got.y, got.z));
                return;
            end
            want = pending_points.pop_front();
            checked++;
            if (want.pos.last)
                grid_ends++;
            compare_field("value", v, want.value, want.pos);
            compare_field("pos_x", 32'(got.x), 32'(want.pos.x), want.pos);
            compare_field("pos_y", 32'(got.y), 32'(want.pos.y), want.pos);
            compare_field("pos_z", 32'(got.z), 32'(want.pos.z), want.pos);
            compare_field("last", 32'(got.last), 32'(want.pos.last), want.pos);
        endtask
    endclass

    stencil_model sb;
    int           requests_sent = 0;
    int           setups        = 0;
    int           setups_3d     = 0;
    int           cycle_count   = 0;
    bit           calm          = 1'b0;
    int           hold_left     = 0;
    int           free_left     = 0;

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding.",
                     cycle_count, sb.pending_points.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            sb.check_point(value, {pos_x, pos_y, pos_z, last});
    end

    // Receiver back-pressure: stall bursts of random length between free
    // stretches of varying length, switched off near the end of the run.
    always @(posedge clk)
    begin
        logic stall_now;
        if (calm)
            stall_now = 1'b0;
        else if (hold_left > 0)
        begin
            stall_now = 1'b1;
            hold_left--;
        end
        else if (free_left > 0)
        begin
            stall_now = 1'b0;
            free_left--;
        end
        else
        begin
            stall_now = 1'b1;
            hold_left = $urandom_range(1, 8) - 1;
            free_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 10);
        end
        out_stall <= stall_now;
    end

    function automatic logic [SAMPLE_W-1:0] corner_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            4:       return 32'h0001_0000;
            5:       return 32'hFFFF_0000;
            6:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] data_word();
        case ($urandom_range(0, 9))
            0, 1:    return corner_word();
            2, 3, 4: return $urandom_range(0, 32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    // Half gain with odd sums lands exactly on rounding ties.
    function automatic logic [SAMPLE_W-1:0] gain_word();
        case ($urandom_range(0, 8))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'h0000_0000;
            3:       return 32'h0001_0000;
            4:       return 32'hFFFF_0000;
            5:       return 32'h0000_8000;
            6:       return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            7:       return 32'h0000_0001;
            default: return $urandom;
        endcase
    endfunction

    // Mostly small sizes; values below 3 and above the maximum act as limits.
    function automatic logic [CFG_DIM_W-1:0] dim_choice(bit allow_big);
        case ($urandom_range(0, 15))
            0:       return $urandom_range(0, 2);
            1:       return allow_big ? 7'($urandom_range(65, 127)) : 7'd3;
            2:       return allow_big ? 7'd64 : 7'd5;
            default: return $urandom_range(3, allow_big ? 10 : 5);
        endcase
    endfunction

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [SAMPLE_W-1:0] d);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        sb.apply_reg(idx, d);
    endtask

    task automatic send_request(input logic [SAMPLE_W-1:0] s, input logic [SAMPLE_W-1:0] p);
        in_valid     <= 1'b1;
        sample       <= s;
        prior_output <= p;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.absorb_sample(s, p);
        requests_sent++;
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending_points.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_requests(input int count, input bit corners);
        bit gappy;
        gappy = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < count; i++)
        begin
            if (i > 0 && !calm)
            begin
                if (gappy && $urandom_range(0, 4) == 0)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge clk);
                end
                else if ($urandom_range(0, 249) == 0)
                begin
                    // Hold off new requests until the pipeline has drained.
                    in_valid <= 1'b0;
                    do
                        @(posedge clk);
                    while (sb.pending_points.size() != 0);
                end
            end
            if (requests_sent >= ITEM_TARGET - CALM_ITEMS)
                calm = 1'b1;
            if (corners)
                send_request(corner_word(), corner_word());
            else
                send_request(data_word(), data_word());
        end
    endtask

    // Count zero picks a length that covers whole grids for small geometry
    // and a few rows or planes past the first results for large geometry.
    task automatic run_setup(input bit geo, input bit d3, input logic [CFG_DIM_W-1:0] lx,
                             input logic [CFG_DIM_W-1:0] ly, input logic [CFG_DIM_W-1:0] lz,
                             input logic [SAMPLE_W-1:0] g, input bit acc,
                             input int count, input bit corners);
        logic [SAMPLE_W-1:0] junk;
        int                  n, pts, back;
        junk = $urandom;
        if (geo)
        begin
            program_reg(REG_THREE_DIM, {junk[31:1], d3});
            program_reg(REG_ROW_LENGTH, {junk[31:7], lx});
            program_reg(REG_ROWS_PLANE, {junk[30:6], ly});
            program_reg(REG_PLANE_COUNT, {junk[29:5], lz});
        end
        program_reg(REG_GAIN, g);
        program_reg(REG_ACCUMULATE, {junk[31:1], acc});
        if (!geo && $urandom_range(0, 1) == 1)
            program_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_LO : REG_SPARE_HI, $urandom);
        cfg_write <= 1'b0;
        setups++;
        if (sb.three_d)
            setups_3d++;
        n = count;
        if (n == 0)
        begin
            pts  = sb.grid_points();
            back = sb.stride();
            if (pts <= 300)
                n = pts * $urandom_range(1, 2) + $urandom_range(0, pts - 1);
            else
                n = 2 * back + $urandom_range(1, 2 * back);
        end
        run_requests(n, corners);
        settle();
    endtask

    initial
    begin
        int                   phase_no;
        bit                   d3;
        logic [CFG_DIM_W-1:0] lx, ly, lz;
        phase_no = 0;
        sb = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Settings straight out of reset: 2D, 64 by 64, unit gain.
        run_requests(140, 1'b0);
        settle();

        // Directed: saturating 2D grid with a short row length, then a 3D grid
        // up to its one interior point with accumulation, most negative gain and a short plane.
        run_setup(1'b1, 1'b0, 7'd1, 7'd3, 7'd0, 32'h7FFF_FFFF, 1'b0, 9, 1'b1);
        run_setup(1'b1, 1'b1, 7'd3, 7'd2, 7'd3, 32'h8000_0000, 1'b1, 23, 1'b1);

        while (requests_sent < ITEM_TARGET)
        begin
            phase_no++;
            d3 = ($urandom_range(0, 2) == 0);
            lx = dim_choice(!d3);
            ly = dim_choice(!d3);
            lz = dim_choice(1'b0);
            case (phase_no)
                2:       run_setup(1'b1, 1'b0, 7'd64, 7'd3, lz, gain_word(),
                                   $urandom_range(0, 1), 0, 1'b0);
                5:       run_setup(1'b1, 1'b0, 7'd3, 7'd64, lz, gain_word(),
                                   $urandom_range(0, 1), 0, 1'b0);
                8:       run_setup(1'b1, 1'b1, 7'd3, 7'd3, 7'd127, gain_word(),
                                   $urandom_range(0, 1), 580, 1'b0);
                default: run_setup($urandom_range(0, 3) != 0, d3, lx, ly, lz, gain_word(),
                                   $urandom_range(0, 1), 0, 1'b0);
            endcase
        end

        if (sb.pending_points.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending_points.size()));
        $display("Sent %0d requests over %0d settings (%0d in 3D, some with out-of-range sizes).",
                 requests_sent, setups, setups_3d);
        $display("Checked %0d interior results, %0d of them grid ends; %0d mismatches.",
                 sb.checked, sb.grid_ends, sb.errors);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
